// ----- rtl/core/rlms_pkg.sv -----
// rlms_pkg: shared types, codes and the hue ramp table of the rgb led mode sequencer
// no dependencies; the table is built at elaboration by integer sine evaluation
`default_nettype none

package rlms_pkg;

   localparam int HUE_STEPS     = 360;
   localparam int SECTOR_LEN    = HUE_STEPS / 3;
   localparam int SECTOR_LEN_W  = $clog2(SECTOR_LEN);
   localparam int LEVEL_W       = 8;
   localparam int INTERVAL_W    = 16;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd500;
   localparam logic [LEVEL_W-1:0]    LEVEL_MAX      = 8'd255;

   localparam logic [63:0] PI_Q30    = 64'd3373259426;
   localparam logic [63:0] SQRT3_Q30 = 64'd1859775393;
   localparam logic [63:0] TOL       = 64'd16384;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_SET   = 3'd1,
      OP_BLINK = 3'd2,
      OP_HUE   = 3'd3,
      OP_OFF   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      MODE_STATIC = 2'd0,
      MODE_BLINK  = 2'd1,
      MODE_HUE    = 2'd2
   } mode_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [1:0]         channel;
      logic [2:0]         operation;
   } item_type;

   typedef struct packed {
      logic [1:0]         active_mode;
      logic [LEVEL_W-1:0] blue_level;
      logic [LEVEL_W-1:0] green_level;
      logic [LEVEL_W-1:0] red_level;
   } result_type;

   // entry holds {up, down}
   typedef logic [SECTOR_LEN-1:0][2*LEVEL_W-1:0] rom_type;

   // shift-subtract division, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], num[i]};
         if (r >= den) begin
            r    = r - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // sine in unsigned q30 by truncated taylor series
   function automatic logic [63:0] sin_q30(input logic [31:0] deg);
      logic [63:0] d;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      d = (deg > 32'd180) ? 64'd180 : 64'(deg);
      if (d > 64'd90) d = 64'd180 - d;
      x    = (d * PI_Q30) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
         term = (term * x2) >> 30;
         term = udiv64(term, 64'((2 * n) * (2 * n + 1)));
         if (n[0]) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      return (sum < 0) ? 64'd0 : 64'(sum);
   endfunction

   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] num;
      logic [63:0] up;
      logic [63:0] ceil_up;
      logic [63:0] dn;
      for (int t = 0; t < SECTOR_LEN; t++) begin
         a   = (SQRT3_Q30 * sin_q30(32'(t))) >> 30;
         b   = sin_q30(32'(t + 30));
         num = 64'd85 * a;
         if (b == 64'd0) b = 64'd1;
         up      = udiv64(num + TOL, b);
         ceil_up = udiv64(num + b - 64'd1 + ((b > TOL) ? 64'd0 : TOL) - TOL, b);
         if (up > 64'd255) up = 64'd255;
         dn = (ceil_up > 64'd255) ? 64'd0 : 64'd255 - ceil_up;
         rom[t] = {up[LEVEL_W-1:0], dn[LEVEL_W-1:0]};
      end
      return rom;
   endfunction

   localparam rom_type HUE_ROM = build_rom();

endpackage

`default_nettype wire

// ----- rtl/core/rgb_led_mode_sequencer.sv -----
// rgb_led_mode_sequencer: rgb led level sequencer with static, blink ramp and hue cycle modes
// an accepted item waits in the item register, then updates the state registers that are offered as the result
// throughput: one item per cycle, limited only by the result side taking items
// reset (synchronous): levels zero, static mode, prescaler zero, tick interval 500
// depends on rlms_pkg, rlms_core and rlms_hue_rom
`default_nettype none

module rgb_led_mode_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // operation[2:0], channel[4:3], level[12:5]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // red[7:0], green[15:8], blue[23:16], mode[25:24]
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic [rlms_pkg::INTERVAL_W-1:0] interval_ff, interval_in;
   logic                            in_valid_ff, in_valid_in;
   rlms_pkg::item_type              item_ff, item_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            take;
   logic                            req_take;
   rlms_pkg::result_type            result;

   assign take     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_take = req_tvalid && req_tready;

   assign req_tready   = !in_valid_ff || take;
   assign interval_in  = csr_wr_en ? csr_wr_data : interval_ff;
   assign in_valid_in  = req_take ? 1'b1 : (take ? 1'b0 : in_valid_ff);
   assign item_in      = req_take ? rlms_pkg::item_type'(req_tdata[12:0]) : item_ff;
   assign rsp_valid_in = take ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= rlms_pkg::INTERVAL_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         interval_ff  <= interval_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   rlms_core u_core (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .item          (item_ff),
      .tick_interval (interval_ff),
      .result        (result)
   );

   // state registers double as the result register
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, result};

endmodule

`default_nettype wire

// ----- rtl/core/rlms_hue_rom.sv -----
// rlms_hue_rom: ramp-up and ramp-down levels for one offset within a hue sector
// depends on rlms_pkg for the elaborated table
`default_nettype none

module rlms_hue_rom (
   input  wire logic [rlms_pkg::SECTOR_LEN_W-1:0] offset,
   output logic      [rlms_pkg::LEVEL_W-1:0]      up_level,
   output logic      [rlms_pkg::LEVEL_W-1:0]      down_level
);

   logic [2*rlms_pkg::LEVEL_W-1:0] entry;

   always_comb begin
      if (32'(offset) < rlms_pkg::SECTOR_LEN) begin
         entry = rlms_pkg::HUE_ROM[offset];
      end else begin
         entry = '0;
      end
   end

   assign up_level   = entry[2*rlms_pkg::LEVEL_W-1:rlms_pkg::LEVEL_W];
   assign down_level = entry[rlms_pkg::LEVEL_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/rlms_core.sv -----
// rlms_core: mode state, prescaler and level update for one item per cycle, in cycles where take is high
// depends on rlms_pkg and rlms_hue_rom
`default_nettype none

module rlms_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                take,
   input  wire rlms_pkg::item_type                  item,
   input  wire logic [rlms_pkg::INTERVAL_W-1:0]     tick_interval,
   output rlms_pkg::result_type                     result
);

   localparam int LW = rlms_pkg::LEVEL_W;
   localparam int OW = rlms_pkg::SECTOR_LEN_W;

   logic [LW-1:0] red_ff, red_in;
   logic [LW-1:0] green_ff, green_in;
   logic [LW-1:0] blue_ff, blue_in;
   rlms_pkg::mode_type mode_ff, mode_in;
   logic [1:0] blink_ch_ff, blink_ch_in;
   logic [OW-1:0] hue_off_ff, hue_off_in;
   logic [1:0] hue_sec_ff, hue_sec_in;
   logic [rlms_pkg::INTERVAL_W-1:0] presc_ff, presc_in;

   logic [rlms_pkg::INTERVAL_W-1:0] interval_eff;
   logic [rlms_pkg::INTERVAL_W:0]   presc_inc;
   logic                            fire;
   logic [OW-1:0]                   off_nx;
   logic [1:0]                      sec_nx;
   logic                            off_wrap;
   logic [LW-1:0]                   rom_up;
   logic [LW-1:0]                   rom_down;
   logic [LW-1:0]                   blink_lvl;
   rlms_pkg::op_type                op;

   assign op           = rlms_pkg::op_type'(item.operation);
   assign interval_eff = (tick_interval == '0) ? {{(rlms_pkg::INTERVAL_W-1){1'b0}}, 1'b1}
                                               : tick_interval;
   assign presc_inc    = {1'b0, presc_ff} + {{rlms_pkg::INTERVAL_W{1'b0}}, 1'b1};
   assign fire         = (presc_ff == '0);
   assign off_wrap     = (32'(hue_off_ff) == rlms_pkg::SECTOR_LEN - 1);
   assign off_nx       = off_wrap ? '0 : hue_off_ff + {{(OW-1){1'b0}}, 1'b1};
   assign sec_nx       = off_wrap ? ((hue_sec_ff == 2'd2) ? 2'd0 : hue_sec_ff + 2'd1)
                                  : hue_sec_ff;

   rlms_hue_rom u_hue_rom (
      .offset     (off_nx),
      .up_level   (rom_up),
      .down_level (rom_down)
   );

   always_comb begin
      case (blink_ch_ff)
         2'd1:    blink_lvl = green_ff;
         2'd2:    blink_lvl = blue_ff;
         default: blink_lvl = red_ff;
      endcase
   end

   always_comb begin
      red_in      = red_ff;
      green_in    = green_ff;
      blue_in     = blue_ff;
      mode_in     = mode_ff;
      blink_ch_in = blink_ch_ff;
      hue_off_in  = hue_off_ff;
      hue_sec_in  = hue_sec_ff;
      presc_in    = presc_ff;
      if (take) begin
         unique case (op)
            rlms_pkg::OP_TICK: begin
               presc_in = (presc_inc >= {1'b0, interval_eff}) ? '0
                                                              : presc_inc[rlms_pkg::INTERVAL_W-1:0];
               if (fire && mode_ff == rlms_pkg::MODE_BLINK) begin
                  if (blink_lvl == rlms_pkg::LEVEL_MAX) begin
                     red_in   = '0;
                     green_in = '0;
                     blue_in  = '0;
                     case (blink_ch_ff)
                        2'd1:    blink_ch_in = 2'd2;
                        2'd2:    blink_ch_in = 2'd0;
                        default: blink_ch_in = 2'd1;
                     endcase
                  end else begin
                     case (blink_ch_ff)
                        2'd1:    green_in = green_ff + 8'd1;
                        2'd2:    blue_in  = blue_ff + 8'd1;
                        default: red_in   = red_ff + 8'd1;
                     endcase
                  end
               end else if (fire && mode_ff == rlms_pkg::MODE_HUE) begin
                  hue_off_in = off_nx;
                  hue_sec_in = sec_nx;
                  case (sec_nx)
                     2'd0: begin
                        red_in   = rom_down;
                        green_in = rom_up;
                        blue_in  = '0;
                     end
                     2'd1: begin
                        green_in = rom_down;
                        blue_in  = rom_up;
                        red_in   = '0;
                     end
                     default: begin
                        blue_in  = rom_down;
                        red_in   = rom_up;
                        green_in = '0;
                     end
                  endcase
               end
            end
            rlms_pkg::OP_SET: begin
               case (item.channel)
                  2'd0: begin
                     red_in  = item.level;
                     mode_in = rlms_pkg::MODE_STATIC;
                  end
                  2'd1: begin
                     green_in = item.level;
                     mode_in  = rlms_pkg::MODE_STATIC;
                  end
                  2'd2: begin
                     blue_in = item.level;
                     mode_in = rlms_pkg::MODE_STATIC;
                  end
                  default: begin
                     mode_in = mode_ff;
                  end
               endcase
            end
            rlms_pkg::OP_BLINK: begin
               red_in      = '0;
               green_in    = '0;
               blue_in     = '0;
               mode_in     = rlms_pkg::MODE_BLINK;
               blink_ch_in = 2'd0;
            end
            rlms_pkg::OP_HUE: begin
               red_in     = '0;
               green_in   = '0;
               blue_in    = '0;
               mode_in    = rlms_pkg::MODE_HUE;
               hue_off_in = '0;
               hue_sec_in = 2'd0;
            end
            rlms_pkg::OP_OFF: begin
               red_in   = '0;
               green_in = '0;
               blue_in  = '0;
               mode_in  = rlms_pkg::MODE_STATIC;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff      <= '0;
         green_ff    <= '0;
         blue_ff     <= '0;
         mode_ff     <= rlms_pkg::MODE_STATIC;
         blink_ch_ff <= 2'd0;
         hue_off_ff  <= '0;
         hue_sec_ff  <= 2'd0;
         presc_ff    <= '0;
      end else begin
         red_ff      <= red_in;
         green_ff    <= green_in;
         blue_ff     <= blue_in;
         mode_ff     <= mode_in;
         blink_ch_ff <= blink_ch_in;
         hue_off_ff  <= hue_off_in;
         hue_sec_ff  <= hue_sec_in;
         presc_ff    <= presc_in;
      end
   end

   assign result.red_level   = red_ff;
   assign result.green_level = green_ff;
   assign result.blue_level  = blue_ff;
   assign result.active_mode = mode_ff;

   // blink ramp lights at most one channel
   assert property (@(posedge clock) disable iff (reset)
      mode_ff == rlms_pkg::MODE_BLINK |->
         $countones({red_ff != '0, green_ff != '0, blue_ff != '0}) <= 1)
      else $error("blink mode with more than one channel lit");

   // hue cycle always leaves one channel dark
   assert property (@(posedge clock) disable iff (reset)
      mode_ff == rlms_pkg::MODE_HUE |-> (red_ff == '0 || green_ff == '0 || blue_ff == '0))
      else $error("hue mode with all channels lit");

   // a tick off the prescale changes no level or mode
   assert property (@(posedge clock) disable iff (reset)
      take && op == rlms_pkg::OP_TICK && presc_ff != '0 |=>
         $stable(red_ff) && $stable(green_ff) && $stable(blue_ff) && $stable(mode_ff))
      else $error("levels moved on a tick off the prescale");

   assert property (@(posedge clock) disable iff (reset)
      32'(hue_off_ff) < rlms_pkg::SECTOR_LEN && hue_sec_ff != 2'd3 && blink_ch_ff != 2'd3)
      else $error("hue position or blink channel out of range");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for rgb_led_mode_sequencer, with its own level predictor
// drives random and directed items over the request stream and checks every response
// depends on rlms_pkg and the rgb_led_mode_sequencer rtl
`default_nettype none

module testbench;

   localparam logic [2:0]  OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0]  OP_UNUSED_LAST  = 3'd7;
   localparam logic [1:0]  CH_RED          = 2'd0;
   localparam logic [1:0]  CH_GREEN        = 2'd1;
   localparam logic [1:0]  CH_BLUE         = 2'd2;
   localparam logic [1:0]  CH_NONE         = 2'd3;
   localparam logic [15:0] DEFAULT_SPAN    = 16'd500;
   localparam logic [15:0] LONGEST_SPAN    = 16'hFFFF;
   localparam int          FULL_TURN       = 360;
   localparam int          SECTOR          = FULL_TURN / 3;
   localparam longint unsigned HALF_TURN_Q30 = 64'd3373259426;
   localparam longint unsigned ROOT3_Q30     = 64'd1859775393;
   localparam longint unsigned ROUND_TOL     = 64'd16384;
   localparam int          HOLD_CYCLES     = 300;
   localparam int          STALL_LIMIT     = 2000;
   localparam int          SETTLE_CYCLES   = 8;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   // predictor state
   logic [7:0]            lamp [3];
   rlms_pkg::mode_type    lamp_mode;
   logic [1:0]            blink_sel;
   int unsigned           hue_pos;
   int unsigned           prescale;
   logic [15:0]           tick_span;
   logic [7:0]            ramp_up_tbl [SECTOR];
   logic [7:0]            ramp_dn_tbl [SECTOR];
   rlms_pkg::result_type  pending_levels [$];

   bit           idle_free;
   bit           long_hold;
   int           error_count;
   int           items_sent;
   int           results_checked;
   int           blink_moves;
   int           hue_wraps;

   rgb_led_mode_sequencer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint unsigned q30_sine(int unsigned deg);
      int unsigned       d;
      longint unsigned   x;
      longint unsigned   x2;
      longint unsigned   term;
      longint            acc;
      d = (deg > 180) ? 180 : deg;
      if (d > 90) d = 180 - d;
      x    = longint'(d) * HALF_TURN_Q30 / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
         term = (term * x2) >> 30;
         term = term / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      return (acc < 0) ? 64'd0 : longint'(acc);
   endfunction

   // hsi ramps at full saturation and intensity, truncated
   task automatic build_ramps();
      longint unsigned a;
      longint unsigned b;
      longint unsigned num;
      longint unsigned up;
      longint unsigned ceil_up;
      for (int t = 0; t < SECTOR; t++) begin
         a   = (ROOT3_Q30 * q30_sine(t)) >> 30;
         b   = q30_sine(t + 30);
         num = 64'd85 * a;
         if (b == 0) b = 1;
         up      = (num + ROUND_TOL) / b;
         ceil_up = (num + b - 1 + ((b > ROUND_TOL) ? 64'd0 : ROUND_TOL) - ROUND_TOL) / b;
         if (up > 255) up = 255;
         ramp_up_tbl[t] = up[7:0];
         ramp_dn_tbl[t] = (ceil_up > 255) ? 8'd0 : 8'(255 - ceil_up);
      end
   endtask

   task automatic apply_item(logic [2:0] op, logic [1:0] ch, logic [7:0] lv);
      int unsigned          span;
      bit                   fire;
      int unsigned          c;
      int unsigned          sec;
      int unsigned          off;
      rlms_pkg::result_type r;
      case (op)
         rlms_pkg::OP_TICK: begin
            span     = (tick_span == 0) ? 1 : tick_span;
            fire     = (prescale == 0);
            prescale = (prescale + 1 >= span) ? 0 : prescale + 1;
            if (fire && lamp_mode == rlms_pkg::MODE_BLINK) begin
               c = (blink_sel > 2) ? 0 : blink_sel;
               if (lamp[c] == 8'd255) begin
                  lamp[0] = '0; lamp[1] = '0; lamp[2] = '0;
                  blink_sel = 2'((c + 1) % 3);
                  blink_moves++;
               end else begin
                  lamp[c] = lamp[c] + 8'd1;
               end
            end else if (fire && lamp_mode == rlms_pkg::MODE_HUE) begin
               hue_pos = (hue_pos + 1 >= FULL_TURN) ? 0 : hue_pos + 1;
               if (hue_pos == 0) hue_wraps++;
               sec = hue_pos / SECTOR;
               off = hue_pos % SECTOR;
               lamp[sec]           = ramp_dn_tbl[off];
               lamp[(sec + 1) % 3] = ramp_up_tbl[off];
               lamp[(sec + 2) % 3] = '0;
            end
         end
         rlms_pkg::OP_SET: begin
            if (ch != CH_NONE) begin
               lamp_mode = rlms_pkg::MODE_STATIC;
               lamp[ch]  = lv;
            end
         end
         rlms_pkg::OP_BLINK: begin
            lamp[0] = '0; lamp[1] = '0; lamp[2] = '0;
            lamp_mode = rlms_pkg::MODE_BLINK;
            blink_sel = '0;
         end
         rlms_pkg::OP_HUE: begin
            lamp[0] = '0; lamp[1] = '0; lamp[2] = '0;
            lamp_mode = rlms_pkg::MODE_HUE;
            hue_pos   = 0;
         end
         rlms_pkg::OP_OFF: begin
            lamp[0] = '0; lamp[1] = '0; lamp[2] = '0;
            lamp_mode = rlms_pkg::MODE_STATIC;
         end
         default: ;
      endcase
      r.red_level   = lamp[0];
      r.green_level = lamp[1];
      r.blue_level  = lamp[2];
      r.active_mode = lamp_mode;
      pending_levels.insert(pending_levels.size(), r);
   endtask

   function automatic int unsigned gap_len();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 80) return $urandom_range(3, 1);
      else if (roll < 97) return $urandom_range(12, 4);
      else return $urandom_range(60, 20);
   endfunction

   task automatic note_error(string msg);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic send_item(logic [2:0] op, logic [1:0] ch, logic [7:0] lv);
      int unsigned n;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {3'b000, lv, ch, op};
      do @(posedge clock); while (!req_tready);
      apply_item(op, ch, lv);
      items_sent++;
      if (!idle_free && $urandom_range(1) == 1) begin
         n = gap_len();
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic send_random();
      int unsigned roll;
      logic [2:0]  op;
      roll = $urandom_range(99);
      if (roll < 55) op = rlms_pkg::OP_TICK;
      else if (roll < 75) op = rlms_pkg::OP_SET;
      else if (roll < 82) op = rlms_pkg::OP_BLINK;
      else if (roll < 89) op = rlms_pkg::OP_HUE;
      else if (roll < 95) op = rlms_pkg::OP_OFF;
      else op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      send_item(op, 2'($urandom_range(CH_NONE, CH_RED)), 8'($urandom_range(255)));
   endtask

   // ticks with a sprinkling of unused codes that leave the state alone
   task automatic send_ticks(int count);
      repeat (count) begin
         if ($urandom_range(99) < 3)
            send_item(3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)),
                      2'($urandom_range(3)), 8'($urandom_range(255)));
         else
            send_item(rlms_pkg::OP_TICK, 2'($urandom_range(3)), 8'($urandom_range(255)));
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
   endtask

   task automatic write_interval(logic [15:0] span);
      drain();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = span;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      tick_span   = span;
   endtask

   task automatic test_commands();
      send_item(rlms_pkg::OP_SET, CH_RED, 8'hFF);
      send_item(rlms_pkg::OP_SET, CH_GREEN, 8'h55);
      send_item(rlms_pkg::OP_SET, CH_BLUE, 8'hAA);
      send_item(rlms_pkg::OP_SET, CH_NONE, 8'hFF);
      send_item(rlms_pkg::OP_SET, CH_BLUE, 8'h00);
      for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
         send_item(3'(op), CH_NONE, 8'hFF);
      send_item(rlms_pkg::OP_TICK, CH_RED, 8'h00);
      send_item(rlms_pkg::OP_BLINK, CH_RED, 8'h00);
      send_item(rlms_pkg::OP_TICK, CH_RED, 8'h00);
      send_item(rlms_pkg::OP_SET, CH_GREEN, 8'h01);
      send_item(rlms_pkg::OP_OFF, CH_RED, 8'h00);
      send_item(rlms_pkg::OP_HUE, CH_RED, 8'h00);
      send_item(rlms_pkg::OP_TICK, CH_RED, 8'h00);
      send_item(rlms_pkg::OP_OFF, CH_RED, 8'h00);
   endtask

   task automatic test_interval_shrink();
      write_interval(16'd7);
      send_item(rlms_pkg::OP_BLINK, CH_RED, 8'h00);
      send_ticks(5);
      write_interval(16'd3);
      send_ticks(5);
   endtask

   task automatic test_hue_sweep();
      write_interval(16'd1);
      idle_free = 1'b1;
      send_item(rlms_pkg::OP_HUE, CH_RED, 8'h00);
      send_ticks(150);
      idle_free = 1'b0;
      send_ticks(250);
   endtask

   task automatic test_blink_sweep();
      write_interval(16'd1);
      send_item(rlms_pkg::OP_BLINK, CH_RED, 8'h00);
      send_ticks(840);
   endtask

   task automatic test_interval_limits();
      write_interval(LONGEST_SPAN);
      send_item(rlms_pkg::OP_HUE, CH_RED, 8'h00);
      send_ticks(20);
      write_interval(16'd0);
      repeat (20) send_random();
      write_interval(DEFAULT_SPAN);
      send_ticks(10);
   endtask

   task automatic test_mixed();
      repeat (4) begin
         if ($urandom_range(1) == 1) write_interval(16'($urandom_range(4, 0)));
         else write_interval(16'($urandom_range(40, 5)));
         repeat (150) send_random();
      end
   endtask

   task automatic test_backpressure();
      drain();
      long_hold = 1'b1;
      idle_free = 1'b1;
      repeat (40) send_random();
      idle_free = 1'b0;
      drain();
   endtask

   always @(posedge clock) begin : result_check
      rlms_pkg::result_type got;
      rlms_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(rlms_pkg::result_type)-1:0];
         if (pending_levels.size() == 0) begin
            note_error($sformatf("response %h with no item outstanding", rsp_tdata));
         end else begin
            want = pending_levels.pop_front();
            results_checked++;
            if (got.red_level !== want.red_level)
               note_error($sformatf("red %0d, expected %0d", got.red_level, want.red_level));
            if (got.green_level !== want.green_level)
               note_error($sformatf("green %0d, expected %0d",
                                    got.green_level, want.green_level));
            if (got.blue_level !== want.blue_level)
               note_error($sformatf("blue %0d, expected %0d", got.blue_level, want.blue_level));
            if (got.active_mode !== want.active_mode)
               note_error($sformatf("mode %0d, expected %0d",
                                    got.active_mode, want.active_mode));
         end
      end
   end

   initial begin : receiver
      int unsigned n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end else if (idle_free || $urandom_range(3) != 0) begin
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = 1'b0;
            n = gap_len();
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en || reset)
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("no progress for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : main
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      idle_free   = 1'b0;
      long_hold   = 1'b0;
      lamp[0] = '0; lamp[1] = '0; lamp[2] = '0;
      lamp_mode = rlms_pkg::MODE_STATIC;
      blink_sel = '0;
      hue_pos   = 0;
      prescale  = 0;
      tick_span = DEFAULT_SPAN;
      build_ramps();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_commands();
      test_interval_shrink();
      test_hue_sweep();
      test_blink_sweep();
      test_interval_limits();
      test_backpressure();
      test_mixed();

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d items sent, %0d responses checked, %0d errors", items_sent,
               results_checked, error_count);
      $display("blink channel moves %0d, hue wraps %0d, intervals 0 to 65535, long hold-off",
               blink_moves, hue_wraps);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// ----- rgb_led_mode_sequencer.f -----
rtl/core/rlms_pkg.sv
rtl/core/rlms_hue_rom.sv
rtl/core/rlms_core.sv
rtl/core/rgb_led_mode_sequencer.sv
tb/sv/testbench.sv
